// ===== rtl/rse_pkg.sv =====
`default_nettype none

package rse_pkg;

   localparam int MAX_PARITY = 30;
   localparam int RESULT_CAP = 30;
   localparam int MIN_PARITY = 7;
   localparam int MAX_COUNT  = (MAX_PARITY < RESULT_CAP) ? MAX_PARITY : RESULT_CAP;
   localparam int CNT_W      = $clog2(MAX_PARITY + 1);
   localparam int CSR_W      = 5;
   localparam logic [8:0] GF_POLY = 9'h11D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_parity;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_head_type;

   typedef logic [MAX_PARITY:0][7:0] gen_row_type;
   typedef gen_row_type [MAX_PARITY:0] gen_table_type;

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] x;
      logic [7:0] r;
      x = {1'b0, a};
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            r = r ^ x[7:0];
         end
         x = x << 1;
         if (x[8]) begin
            x = x ^ GF_POLY;
         end
      end
      return r;
   endfunction

   function automatic gen_table_type build_gen_table();
      gen_table_type t;
      gen_row_type   g;
      logic [7:0]    alpha;
      t = '0;
      for (int n = 0; n <= MAX_PARITY; n++) begin
         g     = '0;
         g[0]  = 8'd1;
         alpha = 8'd1;
         for (int i = 0; i < n; i++) begin
            for (int j = i + 1; j > 0; j--) begin
               g[j] = g[j] ^ gf_mul(alpha, g[j - 1]);
            end
            alpha = gf_mul(alpha, 8'd2);
         end
         t[n] = g;
      end
      return t;
   endfunction

   localparam gen_table_type GEN_TABLE = build_gen_table();

endpackage

`default_nettype wire

// ===== rtl/reed_solomon_parity_encoder.sv =====
`default_nettype none

// Systematic Reed-Solomon encoder over GF(256), field polynomial 0x11D, generator
// prod (x + alpha^i) for i below n. Each request carries one data byte, which is echoed on
// the response channel; on the byte flagged block_end the n parity bytes follow, highest
// order first, and the remainder is cleared. csr_write_data sets n; values below 7 act as
// 7 and values above 30 as 30. Write it only while no request is in flight. Ordinary bytes
// go through at one per cycle while rsp_ready is high; after the last byte of a block the
// parity bytes shift out of the remainder register one per cycle, again gated by rsp_ready,
// and no request is popped meanwhile. Requests pass a two-entry queue, then rsp_ff.
module reed_solomon_parity_encoder
   import rse_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_item,
   input  wire logic             csr_write_en,
   input  wire logic [CSR_W-1:0] csr_write_data
);

   logic [CNT_W-1:0] n_eff_ff, n_eff_in;
   queue_head_type   head;
   logic             pop;

   always_comb begin
      if (CNT_W'(csr_write_data) < CNT_W'(MIN_PARITY)) begin
         n_eff_in = CNT_W'(MIN_PARITY);
      end else if (CNT_W'(csr_write_data) > CNT_W'(MAX_COUNT)) begin
         n_eff_in = CNT_W'(MAX_COUNT);
      end else begin
         n_eff_in = CNT_W'(csr_write_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_eff_ff <= CNT_W'(MIN_PARITY);
      end else if (csr_write_en) begin
         n_eff_ff <= n_eff_in;
      end
   end

   rse_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .head      (head),
      .pop       (pop)
   );

   rse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .n_eff     (n_eff_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ===== rtl/rse_front.sv =====
`default_nettype none

module rse_front
   import rse_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire req_type        req_item,
   output queue_head_type      head,
   input  wire logic           pop
);

   req_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       take;

   assign req_ready  = (count_ff != 2'd2);
   assign push       = req_valid && req_ready;
   assign take       = pop && (count_ff != 2'd0);
   assign head.valid = (count_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(take);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("request queue overfilled");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("request queue pointers disagree with count");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2) |-> !req_ready)
      else $error("request taken into full queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/rse_back.sv =====
`default_nettype none

module rse_back
   import rse_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CNT_W-1:0] n_eff,
   input  wire queue_head_type   head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_item
);

   logic [7:0]       rem_ff [MAX_PARITY];
   logic [7:0]       rem_in [MAX_PARITY];
   logic [7:0]       shifted [MAX_PARITY];
   logic [7:0]       update [MAX_PARITY];
   logic             par_active_ff, par_active_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   gen_row_type      coef;
   logic [7:0]       fb;
   logic             out_free;
   logic             final_parity;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign pop          = head.valid && out_free && !par_active_ff;
   assign coef         = GEN_TABLE[n_eff];
   assign fb           = head.item.data_byte ^ rem_ff[0];
   assign final_parity = (CNT_W'(cnt_ff + 1'b1) == n_eff);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_item     = rsp_ff;

   for (genvar k = 0; k < MAX_PARITY; k++) begin : g_tap
      if (k < MAX_PARITY - 1) begin : g_mid
         assign shifted[k] = rem_ff[k + 1];
      end else begin : g_top
         assign shifted[k] = '0;
      end
      always_comb begin
         if (CNT_W'(k + 1) < n_eff) begin
            update[k] = shifted[k] ^ gf_mul(coef[k + 1], fb);
         end else if (CNT_W'(k + 1) == n_eff) begin
            update[k] = gf_mul(coef[k + 1], fb);
         end else begin
            update[k] = rem_ff[k];
         end
      end
   end

   always_comb begin
      rem_in        = rem_ff;
      par_active_in = par_active_ff;
      cnt_in        = cnt_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (par_active_ff) begin
         if (out_free) begin
            rsp_valid_in       = 1'b1;
            rsp_in.out_byte    = rem_ff[0];
            rsp_in.is_parity   = 1'b1;
            rsp_in.run_last    = final_parity;
            cnt_in             = CNT_W'(cnt_ff + 1'b1);
            if (final_parity) begin
               par_active_in = 1'b0;
               for (int k = 0; k < MAX_PARITY; k++) begin
                  rem_in[k] = '0;
               end
            end else begin
               rem_in = shifted;
            end
         end
      end else if (pop) begin
         rsp_valid_in     = 1'b1;
         rsp_in.out_byte  = head.item.data_byte;
         rsp_in.is_parity = 1'b0;
         rsp_in.run_last  = !head.item.block_end;
         rem_in           = update;
         par_active_in    = head.item.block_end;
         cnt_in           = '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         for (int k = 0; k < MAX_PARITY; k++) begin
            rem_ff[k] <= '0;
         end
         par_active_ff <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rem_ff        <= rem_in;
         par_active_ff <= par_active_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_no_pop_in_parity: assert property (@(posedge clock) disable iff (reset)
      par_active_ff |-> !pop)
      else $error("request popped while parity is draining");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      par_active_ff |-> (cnt_ff < n_eff))
      else $error("parity counter past parity count");
   a_clear_after_block: assert property (@(posedge clock) disable iff (reset)
      (par_active_ff && out_free && final_parity) |=>
         (!par_active_ff && rem_ff[0] == 8'd0 && rem_ff[MAX_PARITY-1] == 8'd0))
      else $error("remainder not cleared after last parity byte");
`endif

endmodule

`default_nettype wire

// ===== sim/reed_solomon_parity_encoder_tb.sv =====
`timescale 1ns / 1ps

module reed_solomon_parity_encoder_tb;
   import rse_pkg::*;

   localparam logic [7:0] FIELD_TAPS     = 8'h1D;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         LONG_HOLD      = 300;
   localparam int         RANDOM_PHASES  = 11;
   localparam int         PHASE_BYTES    = 42;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_item = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_item;
   logic                 csr_write_en = 1'b0;
   logic [CSR_W-1:0]     csr_write_data = '0;

   req_type              pending_bytes[$];
   rsp_type              expected_symbols[$];
   rsp_type              next_symbol;
   logic [7:0]           lfsr_rem [MAX_PARITY];
   logic [7:0]           gen_poly [MAX_PARITY + 1];
   int                   parity_n;
   int                   error_count = 0;
   int                   idle_cycles = 0;
   int                   burst_left = 0;
   int                   gap_left = 0;
   int                   hold_left = 0;
   int                   stall_mode = 0;
   int                   mode_left = 0;
   bit                   long_hold_req = 1'b0;
   bit                   long_hold_done = 1'b0;
   logic [CSR_W-1:0]     phase_counts [RANDOM_PHASES] = '{8, 31, 29, 0, 15, 30, 7, 6, 20, 0, 0};

   reed_solomon_parity_encoder DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item       (rsp_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] sh;
      acc = 8'h00;
      sh  = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= sh;
         sh = {sh[6:0], 1'b0} ^ (sh[7] ? FIELD_TAPS : 8'h00);
      end
      return acc;
   endfunction

   task automatic load_generator(logic [CSR_W-1:0] setting);
      logic [7:0] alpha;
      int         n;
      n = int'(setting);
      if (n < MIN_PARITY) n = MIN_PARITY;
      if (n > MAX_COUNT) n = MAX_COUNT;
      parity_n = n;
      foreach (gen_poly[j]) gen_poly[j] = 8'h00;
      gen_poly[0] = 8'h01;
      alpha = 8'h01;
      for (int i = 0; i < n; i++) begin
         for (int j = i + 1; j > 0; j--) begin
            gen_poly[j] ^= gf_times(alpha, gen_poly[j - 1]);
         end
         alpha = gf_times(alpha, 8'h02);
      end
   endtask

   task automatic shift_in_byte(req_type r);
      logic [7:0] fb;
      fb = r.data_byte ^ lfsr_rem[0];
      for (int k = 0; k + 1 < parity_n; k++) begin
         lfsr_rem[k] = lfsr_rem[k + 1] ^ gf_times(gen_poly[k + 1], fb);
      end
      lfsr_rem[parity_n - 1] = gf_times(gen_poly[parity_n], fb);
      expected_symbols.push_back({r.data_byte, 1'b0, !r.block_end});
      if (r.block_end) begin
         for (int k = 0; k < parity_n; k++) begin
            expected_symbols.push_back({lfsr_rem[k], 1'b1, k == parity_n - 1});
         end
         foreach (lfsr_rem[k]) lfsr_rem[k] = 8'h00;
      end
   endtask

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic write_parity_count(logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      load_generator(value);
   endtask

   task automatic wait_drained();
      while (!(pending_bytes.size() == 0 && !req_valid && expected_symbols.size() == 0)) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic queue_blocks(int count, bit leave_open);
      int      run;
      req_type r;
      run = 0;
      for (int i = 0; i < count; i++) begin
         if (run == 0) begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 10);
         end
         case ($urandom_range(0, 7))
            0: r.data_byte = 8'h00;
            1: r.data_byte = 8'hFF;
            default: r.data_byte = 8'($urandom_range(0, 255));
         endcase
         run--;
         r.block_end = (run == 0) || (i == count - 1 && !leave_open);
         if (r.block_end) run = 0;
         pending_bytes.push_back(r);
      end
   endtask

   // request driver: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_item  <= pending_bytes.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_done = 1'b1;
         hold_left      = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(10, 80);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) shift_in_byte(req_item);
         if (rsp_valid && rsp_ready) begin
            if (expected_symbols.size() == 0) begin
               report_mismatch("unexpected response", rsp_item.out_byte, 8'h00);
            end else begin
               next_symbol = expected_symbols.pop_front();
               if (rsp_item.out_byte !== next_symbol.out_byte) begin
                  report_mismatch("out_byte", rsp_item.out_byte, next_symbol.out_byte);
               end
               if (rsp_item.is_parity !== next_symbol.is_parity) begin
                  report_mismatch("is_parity", 8'(rsp_item.is_parity),
                                  8'(next_symbol.is_parity));
               end
               if (rsp_item.run_last !== next_symbol.run_last) begin
                  report_mismatch("run_last", 8'(rsp_item.run_last),
                                  8'(next_symbol.run_last));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("reed_solomon_parity_encoder_tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      foreach (lfsr_rem[k]) lfsr_rem[k] = 8'h00;
      load_generator(CSR_W'(MIN_PARITY));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset count, zero block, extremes, single-byte blocks
      pending_bytes.push_back({8'h00, 1'b1});
      pending_bytes.push_back({8'hFF, 1'b0});
      pending_bytes.push_back({8'h00, 1'b0});
      pending_bytes.push_back({8'h01, 1'b0});
      pending_bytes.push_back({8'h80, 1'b1});
      pending_bytes.push_back({8'hFF, 1'b1});
      pending_bytes.push_back({8'hA5, 1'b0});
      pending_bytes.push_back({8'h5A, 1'b0});
      wait_drained();

      // change count inside an open block, above range
      write_parity_count(5'd31);
      pending_bytes.push_back({8'h3C, 1'b1});
      pending_bytes.push_back({8'hFF, 1'b0});
      pending_bytes.push_back({8'hFF, 1'b1});
      pending_bytes.push_back({8'h12, 1'b0});
      wait_drained();

      // below range, then shrink from the maximum mid-block
      write_parity_count(5'd0);
      pending_bytes.push_back({8'h34, 1'b0});
      pending_bytes.push_back({8'hC3, 1'b1});
      pending_bytes.push_back({8'h7E, 1'b0});
      wait_drained();
      write_parity_count(5'd30);
      pending_bytes.push_back({8'h81, 1'b0});
      wait_drained();
      write_parity_count(5'd6);
      pending_bytes.push_back({8'h00, 1'b0});
      pending_bytes.push_back({8'hFF, 1'b1});
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_parity_count((p >= 9) ? 5'($urandom_range(0, 31)) : phase_counts[p]);
         if (p == 2) long_hold_req = 1'b1;
         queue_blocks(PHASE_BYTES, $urandom_range(0, 2) == 0);
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (expected_symbols.size() != 0) begin
         report_mismatch("missing responses", 8'h00, 8'(expected_symbols.size()));
      end
      if (error_count == 0) begin
         $display("reed_solomon_parity_encoder_tb: done, clean");
      end else begin
         $display("reed_solomon_parity_encoder_tb: done, errors");
      end
      $finish;
   end

endmodule
